/* src/smrp_pkg.sv */
// ----------------------------------------------------------------------------
// smrp_pkg
// Shared types and constants for the SGR mouse report parser.
// ----------------------------------------------------------------------------
`default_nettype none

package smrp_pkg;

  localparam int unsigned COORD_BITS_DEF  = 16;
  localparam int unsigned BUTTON_BITS_DEF = 8;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned BTN_OUT_W   = 8;
  localparam int unsigned COORD_OUT_W = 17;
  localparam int unsigned BTN_EXT_W   = 16;
  localparam int unsigned COORD_EXT_W = 32;
  localparam int unsigned DRAG_BIT    = 5;

  localparam logic [CHAR_W-1:0] CH_LT   = 8'h3C;  // '<'
  localparam logic [CHAR_W-1:0] CH_SEMI = 8'h3B;  // ';'
  localparam logic [CHAR_W-1:0] CH_UPM  = 8'h4D;  // 'M'
  localparam logic [CHAR_W-1:0] CH_LOWM = 8'h6D;  // 'm'
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;  // '9'

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BTN,
    PH_X,
    PH_Y
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_DRAG    = 2'd2
  } kind_e;

  typedef struct packed {
    logic clr;
    logic add;
  } acc_op_t;

  typedef struct packed {
    acc_op_t btn;
    acc_op_t x;
    acc_op_t y;
    logic    emit;
    logic    ok;
    logic    release_evt;
  } parse_ctl_t;

endpackage

`default_nettype wire

/* src/smrp_dec_acc.sv */
// ----------------------------------------------------------------------------
// smrp_dec_acc
// Saturating decimal accumulator: acc = min(acc * 10 + digit, all ones); clr zeroes it.
// ----------------------------------------------------------------------------
`default_nettype none

module smrp_dec_acc
  import smrp_pkg::*;
#(
  parameter int unsigned W = COORD_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire acc_op_t            op_i,
  input  wire logic [DIGIT_W-1:0] digit_i,
  output      logic [W-1:0]       acc_o
);

  localparam int unsigned SUM_W = W + 4;

  logic [W-1:0]     acc_q, acc_d;
  logic [SUM_W-1:0] sum;

  // x10 as x8 + x2
  always_comb begin
    sum = (SUM_W'(acc_q) << 3) + (SUM_W'(acc_q) << 1) + SUM_W'(digit_i);
  end

  always_comb begin
    acc_d = acc_q;
    if (op_i.clr) begin
      acc_d = '0;
    end else if (op_i.add) begin
      if (sum[SUM_W-1:W] != '0) begin
        acc_d = '1;
      end else begin
        acc_d = sum[W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

/* src/smrp_ctrl.sv */
// ----------------------------------------------------------------------------
// smrp_ctrl
// Report phase tracking and per-byte decode into accumulator and result
// controls.
// ----------------------------------------------------------------------------
`default_nettype none

module smrp_ctrl
  import smrp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [CHAR_W-1:0] char_i,
  input  wire logic              start_i,
  output      parse_ctl_t        ctl_o
);

  phase_e phase_q, phase_d;
  logic   is_digit;

  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);

  always_comb begin
    phase_d = phase_q;
    if (fire_i) begin
      if (start_i) begin
        phase_d = (char_i == CH_LT) ? PH_BTN : PH_IDLE;
      end else begin
        case (phase_q)
          PH_BTN: begin
            if (char_i == CH_SEMI) begin
              phase_d = PH_X;
            end else if (!is_digit) begin
              phase_d = PH_IDLE;
            end
          end
          PH_X: begin
            if (char_i == CH_SEMI) begin
              phase_d = PH_Y;
            end else if (!is_digit) begin
              phase_d = PH_IDLE;
            end
          end
          PH_Y: begin
            if (!is_digit) begin
              phase_d = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    ctl_o = '0;
    if (fire_i) begin
      if (start_i) begin
        ctl_o.btn.clr = 1'b1;
        ctl_o.x.clr   = 1'b1;
        ctl_o.y.clr   = 1'b1;
        ctl_o.emit    = (char_i != CH_LT);
      end else begin
        case (phase_q)
          PH_BTN: begin
            ctl_o.btn.add = is_digit;
            ctl_o.emit    = !is_digit && (char_i != CH_SEMI);
          end
          PH_X: begin
            ctl_o.x.add = is_digit;
            ctl_o.emit  = !is_digit && (char_i != CH_SEMI);
          end
          PH_Y: begin
            ctl_o.y.add       = is_digit;
            ctl_o.emit        = !is_digit;
            ctl_o.ok          = (char_i == CH_UPM) || (char_i == CH_LOWM);
            ctl_o.release_evt = (char_i == CH_LOWM);
          end
          default: begin
            ctl_o = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

/* src/sgr_mouse_report_parser.sv */
// ----------------------------------------------------------------------------
// sgr_mouse_report_parser
// Parses SGR mouse reports ('<' btn ';' x ';' y 'M'/'m') from a byte stream.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | input     | in_valid_i/in_ready_o  | in_char_i, seq_start_i
//   out     | output    | out_valid_o/out_ready_i| parsed_ok_o, event_kind_o,
//           |           |                        | button_code_o, col_x_o, row_y_o
//
// One byte per cycle unless a held result stalls: a request goes from the
// input register through the decode and accumulate logic into the result
// register. Reset clears the phase, accumulators and valid flags; ready after
// reset. A held result stalls the input register only; it keeps one request.
// ----------------------------------------------------------------------------
`default_nettype none

module sgr_mouse_report_parser
  import smrp_pkg::*;
#(
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF,
  parameter int unsigned BUTTON_BITS = BUTTON_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [CHAR_W-1:0]             in_char_i,
  input  wire logic                          seq_start_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          parsed_ok_o,
  output      logic [1:0]                    event_kind_o,
  output      logic [BTN_OUT_W-1:0]          button_code_o,
  output      logic signed [COORD_OUT_W-1:0] col_x_o,
  output      logic signed [COORD_OUT_W-1:0] row_y_o
);

  logic              in_vld_q;
  logic [CHAR_W-1:0] in_char_q;
  logic              in_start_q;
  logic              fire;

  parse_ctl_t ctl;

  logic [BUTTON_BITS-1:0] btn_acc;
  logic [COORD_BITS-1:0]  x_acc;
  logic [COORD_BITS-1:0]  y_acc;

  logic                   is_drag;
  logic [BUTTON_BITS-1:0] btn_masked;
  logic [BTN_EXT_W-1:0]   btn_ext;
  logic [COORD_EXT_W-1:0] x_m1, y_m1;
  kind_e                  kind;

  logic                   out_vld_q;
  logic                   ok_q;
  logic [1:0]             kind_q;
  logic [BTN_OUT_W-1:0]   btn_q;
  logic [COORD_OUT_W-1:0] x_q, y_q;

  assign fire       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_char_q  <= in_char_i;
      in_start_q <= seq_start_i;
    end
  end

  smrp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (fire),
    .char_i  (in_char_q),
    .start_i (in_start_q),
    .ctl_o   (ctl)
  );

  smrp_dec_acc #(.W(BUTTON_BITS)) u_btn_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (ctl.btn),
    .digit_i (in_char_q[DIGIT_W-1:0]),
    .acc_o   (btn_acc)
  );

  smrp_dec_acc #(.W(COORD_BITS)) u_x_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (ctl.x),
    .digit_i (in_char_q[DIGIT_W-1:0]),
    .acc_o   (x_acc)
  );

  smrp_dec_acc #(.W(COORD_BITS)) u_y_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (ctl.y),
    .digit_i (in_char_q[DIGIT_W-1:0]),
    .acc_o   (y_acc)
  );

  always_comb begin
    is_drag    = btn_acc[DRAG_BIT];
    btn_masked = btn_acc;
    btn_masked[DRAG_BIT] = 1'b0;
    btn_ext    = BTN_EXT_W'(btn_masked);
    x_m1       = COORD_EXT_W'(x_acc) - COORD_EXT_W'(1);
    y_m1       = COORD_EXT_W'(y_acc) - COORD_EXT_W'(1);
    if (is_drag) begin
      kind = KIND_DRAG;
    end else if (ctl.release_evt) begin
      kind = KIND_RELEASE;
    end else begin
      kind = KIND_PRESS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && ctl.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && ctl.emit) begin
      if (ctl.ok) begin
        ok_q   <= 1'b1;
        kind_q <= kind;
        btn_q  <= btn_ext[BTN_OUT_W-1:0];
        x_q    <= x_m1[COORD_OUT_W-1:0];
        y_q    <= y_m1[COORD_OUT_W-1:0];
      end else begin
        ok_q   <= 1'b0;
        kind_q <= '0;
        btn_q  <= '0;
        x_q    <= '0;
        y_q    <= '0;
      end
    end
  end

  assign out_valid_o   = out_vld_q;
  assign parsed_ok_o   = ok_q;
  assign event_kind_o  = kind_q;
  assign button_code_o = btn_q;
  assign col_x_o       = x_q;
  assign row_y_o       = y_q;

endmodule

`default_nettype wire
